// ===== src/rth_pkg.sv =====
`default_nettype none
// ============================================================================
// rth_pkg
// Shared types and constants for the ray/triangle hit test pipeline.
// ============================================================================
package rth_pkg;

    localparam int COORD_BITS        = 32;
    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int CFG_INDEX_BITS    = 3;

    // stage counts of the two multiplier layers (one partial product per stage)
    localparam int MUL_A_STAGES = 2;
    localparam int MUL_B_STAGES = 4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_DIR_X    = 3'd3,
        CFG_DIR_Y    = 3'd4,
        CFG_DIR_Z    = 3'd5,
        CFG_EPSILON  = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OUT_HIT      = 2'd0,
        OUT_PARALLEL = 2'd1,
        OUT_BEHIND   = 2'd2,
        OUT_OUTSIDE  = 2'd3
    } outcome_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_y;
        logic signed [COORD_BITS-1:0] a_z;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_y;
        logic signed [COORD_BITS-1:0] b_z;
        logic signed [COORD_BITS-1:0] c_x;
        logic signed [COORD_BITS-1:0] c_y;
        logic signed [COORD_BITS-1:0] c_z;
    } triangle_t;

    typedef struct packed {
        logic                  hit;
        logic [COORD_BITS-2:0] distance;
        outcome_t              outcome;
    } result_t;

endpackage
`default_nettype wire

// ===== src/rth_mul.sv =====
`default_nettype none
// ============================================================================
// rth_mul
// Pipelined signed multiplier: b is split into STAGES digits, one partial
// product accumulated per stage, each stage registered; advances on en.
// ============================================================================
module rth_mul #(
    parameter int A_BITS = 33,
    parameter int B_BITS = 33,
    parameter int STAGES = 2
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [A_BITS-1:0]         a,
    input  logic signed [B_BITS-1:0]         b,
    output logic signed [A_BITS+B_BITS-1:0]  p
);

    localparam int CHUNK    = (B_BITS + STAGES - 1) / STAGES;
    localparam int PAD_BITS = CHUNK * STAGES;
    localparam int ACC_BITS = A_BITS + PAD_BITS + 1;

    logic signed [A_BITS-1:0]   a_reg   [STAGES];
    logic signed [PAD_BITS-1:0] b_reg   [STAGES];
    logic signed [ACC_BITS-1:0] acc_reg [STAGES];

    logic signed [A_BITS-1:0]   a_src   [STAGES];
    logic signed [PAD_BITS-1:0] b_src   [STAGES];
    logic signed [ACC_BITS-1:0] acc_src [STAGES];
    logic signed [A_BITS+CHUNK:0] part  [STAGES];

    always_comb
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (k == 0)
            begin
                a_src[k]   = a;
                b_src[k]   = PAD_BITS'(b);
                acc_src[k] = '0;
            end
            else
            begin
                a_src[k]   = a_reg[k-1];
                b_src[k]   = b_reg[k-1];
                acc_src[k] = acc_reg[k-1];
            end
            // low digits are unsigned, the top digit carries the sign
            if (k == STAGES - 1)
                part[k] = a_src[k] * $signed(b_src[k][k*CHUNK +: CHUNK]);
            else
                part[k] = a_src[k] * $signed({1'b0, b_src[k][k*CHUNK +: CHUNK]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                a_reg[k]   <= a_src[k];
                b_reg[k]   <= b_src[k];
                acc_reg[k] <= acc_src[k] + (ACC_BITS'(part[k]) <<< (k * CHUNK));
            end
        end
    end

    assign p = acc_reg[STAGES-1][A_BITS+B_BITS-1:0];

endmodule
`default_nettype wire

// ===== src/ray_triangle_hit_test.sv =====
`default_nettype none
// ============================================================================
// ray_triangle_hit_test
// Tests a stream of triangles against one configured ray; one result per
// triangle: hit flag, distance t (Q.FRAC_BITS, saturated) and outcome code.
// ============================================================================
//
//  channel | signals                         | moves
//  --------+---------------------------------+------------------------------
//  in      | in_valid, in_stall, in_data     | one triangle per transaction
//  out     | out_valid, out_stall, out_data  | one result per transaction
//  cfg     | cfg_write, cfg_index, cfg_data  | one register write per cycle
//
//  One transaction per cycle sustained while the skid register is empty;
//  the restoring divider produces one quotient bit per stage.
//  Reset clears valid bits and the output skid and sets the ray registers
//  to their defaults: a +z ray from the origin, threshold 1.
//  out_stall on a waiting result parks it in a skid register; the pipeline
//  freezes (in_stall high) only while the skid register is full.
//
//  Edge tests use sign(e . (dir x (v - origin))), equal in sign to the
//  exact n . (e x den*(P - v)) test since |n|^2 > 0 whenever den != 0.
// ============================================================================
module ray_triangle_hit_test #(
    parameter int FRAC_BITS = rth_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  rth_pkg::triangle_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output rth_pkg::result_t                     out_data,
    input  logic                                 cfg_write,
    input  logic [rth_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [rth_pkg::COORD_BITS-1:0]       cfg_data
);

    localparam int CB   = rth_pkg::COORD_BITS;
    localparam int LA   = rth_pkg::MUL_A_STAGES;
    localparam int LB   = rth_pkg::MUL_B_STAGES;
    localparam int EW   = CB + 1;          // vertex differences
    localparam int NW   = 2 * CB + 3;      // normal components
    localparam int XW   = 2 * CB + 2;      // dir x (v - origin) components
    localparam int DW   = 3 * CB + 5;      // N.dir
    localparam int UW   = 3 * CB + 6;      // N.(a - origin)
    localparam int TW   = 3 * CB + 5;      // edge triple products
    localparam int DIVW = (UW + FRAC_BITS > DW + CB) ? UW + FRAC_BITS : DW + CB;
    localparam int NDIV = CB - 1;
    localparam int NV   = 2 + LA + 1 + LB + 3 + NDIV + 1;

    typedef struct packed {
        logic den_zero;
        logic par;
        logic behind;
        logic outside;
        logic sat;
    } flags_t;

    // ---------------- configuration ----------------
    logic signed [CB-1:0] org_reg [3];
    logic signed [CB-1:0] dir_reg [3];
    logic [CB-2:0]        eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= CB'(64'd1 << FRAC_BITS);
            eps_reg    <= (CB-1)'(1);
        end
        else if (cfg_write)
        begin
            unique case (rth_pkg::cfg_reg_t'(cfg_index))
                rth_pkg::CFG_ORIGIN_X: org_reg[0] <= cfg_data;
                rth_pkg::CFG_ORIGIN_Y: org_reg[1] <= cfg_data;
                rth_pkg::CFG_ORIGIN_Z: org_reg[2] <= cfg_data;
                rth_pkg::CFG_DIR_X:    dir_reg[0] <= cfg_data;
                rth_pkg::CFG_DIR_Y:    dir_reg[1] <= cfg_data;
                rth_pkg::CFG_DIR_Z:    dir_reg[2] <= cfg_data;
                rth_pkg::CFG_EPSILON:  eps_reg    <= cfg_data[CB-2:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic             adv;
    logic [NV-1:0]    vld_reg;
    logic             skid_full_reg;
    rth_pkg::result_t skid_data_reg;
    rth_pkg::result_t res_reg;

    assign adv      = !skid_full_reg;
    assign in_stall = skid_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NV-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_full_reg <= 1'b0;
        else if (skid_full_reg)
        begin
            if (!out_stall)
                skid_full_reg <= 1'b0;
        end
        else if (vld_reg[NV-1] && out_stall)
            skid_full_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg && vld_reg[NV-1] && out_stall)
            skid_data_reg <= res_reg;
    end

    assign out_valid = skid_full_reg | vld_reg[NV-1];
    assign out_data  = skid_full_reg ? skid_data_reg : res_reg;

    // ---------------- stage 0/1: capture, differences ----------------
    rth_pkg::triangle_t   tri_reg;
    logic signed [CB-1:0] vtx [3][3];
    logic signed [EW-1:0] edge_reg [3][3];   // b-a, c-b, a-c
    logic signed [EW-1:0] q_reg    [3][3];   // a-o, b-o, c-o

    always_ff @(posedge clk)
    begin
        if (adv)
            tri_reg <= in_data;
    end

    always_comb
    begin
        vtx[0][0] = tri_reg.a_x; vtx[0][1] = tri_reg.a_y; vtx[0][2] = tri_reg.a_z;
        vtx[1][0] = tri_reg.b_x; vtx[1][1] = tri_reg.b_y; vtx[1][2] = tri_reg.b_z;
        vtx[2][0] = tri_reg.c_x; vtx[2][1] = tri_reg.c_y; vtx[2][2] = tri_reg.c_z;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    edge_reg[k][i] <= EW'(vtx[(k+1)%3][i]) - EW'(vtx[k][i]);
                    q_reg[k][i]    <= EW'(vtx[k][i]) - EW'(org_reg[i]);
                end
            end
        end
    end

    // ---------------- multiplier layer A ----------------
    logic signed [2*EW-1:0]  n_p  [3][2];
    logic signed [CB+EW-1:0] dq_p [3][3][2];

    for (genvar i = 0; i < 3; i++)
    begin : g_layer_a
        // n = (a-c) x (b-a)
        rth_mul #(.A_BITS(EW), .B_BITS(EW), .STAGES(LA)) u_n0 (
            .clk(clk), .en(adv),
            .a(edge_reg[2][(i+1)%3]), .b(edge_reg[0][(i+2)%3]), .p(n_p[i][0]));
        rth_mul #(.A_BITS(EW), .B_BITS(EW), .STAGES(LA)) u_n1 (
            .clk(clk), .en(adv),
            .a(edge_reg[2][(i+2)%3]), .b(edge_reg[0][(i+1)%3]), .p(n_p[i][1]));
        for (genvar k = 0; k < 3; k++)
        begin : g_dq
            rth_mul #(.A_BITS(CB), .B_BITS(EW), .STAGES(LA)) u_x0 (
                .clk(clk), .en(adv),
                .a(dir_reg[(i+1)%3]), .b(q_reg[k][(i+2)%3]), .p(dq_p[k][i][0]));
            rth_mul #(.A_BITS(CB), .B_BITS(EW), .STAGES(LA)) u_x1 (
                .clk(clk), .en(adv),
                .a(dir_reg[(i+2)%3]), .b(q_reg[k][(i+1)%3]), .p(dq_p[k][i][1]));
        end
    end

    // edges and a-o wait for the normal
    logic signed [EW-1:0] side_edge_reg [LA+1][3][3];
    logic signed [EW-1:0] side_q_reg    [LA+1][3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_edge_reg[0] <= edge_reg;
            side_q_reg[0]    <= q_reg[0];
            for (int s = 1; s <= LA; s++)
            begin
                side_edge_reg[s] <= side_edge_reg[s-1];
                side_q_reg[s]    <= side_q_reg[s-1];
            end
        end
    end

    // ---------------- stage 2: cross products ----------------
    logic signed [NW-1:0] n_reg  [3];
    logic signed [XW-1:0] dq_reg [3][3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                n_reg[i] <= NW'(n_p[i][0]) - NW'(n_p[i][1]);
                for (int k = 0; k < 3; k++)
                    dq_reg[k][i] <= XW'(dq_p[k][i][0]) - XW'(dq_p[k][i][1]);
            end
        end
    end

    // ---------------- multiplier layer B ----------------
    logic signed [CB+NW-1:0] den_p  [3];
    logic signed [EW+NW-1:0] num_p  [3];
    logic signed [EW+XW-1:0] trip_p [3][3];

    for (genvar i = 0; i < 3; i++)
    begin : g_layer_b
        rth_mul #(.A_BITS(CB), .B_BITS(NW), .STAGES(LB)) u_den (
            .clk(clk), .en(adv), .a(dir_reg[i]), .b(n_reg[i]), .p(den_p[i]));
        rth_mul #(.A_BITS(EW), .B_BITS(NW), .STAGES(LB)) u_num (
            .clk(clk), .en(adv), .a(side_q_reg[LA][i]), .b(n_reg[i]), .p(num_p[i]));
        for (genvar k = 0; k < 3; k++)
        begin : g_trip
            rth_mul #(.A_BITS(EW), .B_BITS(XW), .STAGES(LB)) u_trip (
                .clk(clk), .en(adv),
                .a(side_edge_reg[LA][k][i]), .b(dq_reg[k][i]), .p(trip_p[k][i]));
        end
    end

    // ---------------- stage 3: dot product sums ----------------
    logic signed [DW-1:0] den_reg;
    logic signed [UW-1:0] num_reg;
    logic signed [TW-1:0] trip_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg <= DW'(den_p[0]) + DW'(den_p[1]) + DW'(den_p[2]);
            num_reg <= UW'(num_p[0]) + UW'(num_p[1]) + UW'(num_p[2]);
            for (int k = 0; k < 3; k++)
                trip_reg[k] <= TW'(trip_p[k][0]) + TW'(trip_p[k][1]) + TW'(trip_p[k][2]);
        end
    end

    // ---------------- stage 4: magnitudes and sign tests ----------------
    logic [DW-1:0] ad4_reg;
    logic [UW-1:0] an4_reg;
    flags_t        f4_reg;
    flags_t        f4_next;
    logic          den_neg;

    assign den_neg = den_reg[DW-1];

    always_comb
    begin
        f4_next          = '0;
        f4_next.den_zero = (den_reg == '0);
        f4_next.behind   = (num_reg != '0) && (num_reg[UW-1] != den_neg);
        for (int k = 0; k < 3; k++)
        begin
            if ((trip_reg[k] != '0) && (trip_reg[k][TW-1] != den_neg))
                f4_next.outside = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ad4_reg <= den_neg ? DW'(-den_reg) : DW'(den_reg);
            an4_reg <= num_reg[UW-1] ? UW'(-num_reg) : UW'(num_reg);
            f4_reg  <= f4_next;
        end
    end

    // ---------------- stage 5: threshold and saturation ----------------
    logic [DIVW-1:0] rem5_reg;
    logic [DW-1:0]   ad5_reg;
    flags_t          f5_reg;
    flags_t          f5_next;
    logic [DIVW-1:0] rem5_next;

    always_comb
    begin
        rem5_next   = DIVW'(an4_reg) << FRAC_BITS;
        f5_next     = f4_reg;
        f5_next.par = f4_reg.den_zero ||
                      (DIVW'(ad4_reg) < (DIVW'(eps_reg) << (2 * FRAC_BITS)));
        f5_next.sat = rem5_next >= (DIVW'(ad4_reg) << (CB - 1));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem5_reg <= rem5_next;
            ad5_reg  <= ad4_reg;
            f5_reg   <= f5_next;
        end
    end

    // ---------------- restoring divider, one bit per stage ----------------
    logic [DIVW-1:0] div_rem_reg [NDIV];
    logic [CB-2:0]   div_q_reg   [NDIV];
    logic [DW-1:0]   div_ad_reg  [NDIV];
    flags_t          div_f_reg   [NDIV];

    logic [DIVW-1:0] div_rem_src  [NDIV];
    logic [CB-2:0]   div_q_src    [NDIV];
    logic [DW-1:0]   div_ad_src   [NDIV];
    flags_t          div_f_src    [NDIV];
    logic [DIVW-1:0] div_rem_next [NDIV];
    logic [CB-2:0]   div_q_next   [NDIV];
    logic [DIVW-1:0] trial        [NDIV];

    always_comb
    begin
        for (int j = 0; j < NDIV; j++)
        begin
            if (j == 0)
            begin
                div_rem_src[j] = rem5_reg;
                div_q_src[j]   = '0;
                div_ad_src[j]  = ad5_reg;
                div_f_src[j]   = f5_reg;
            end
            else
            begin
                div_rem_src[j] = div_rem_reg[j-1];
                div_q_src[j]   = div_q_reg[j-1];
                div_ad_src[j]  = div_ad_reg[j-1];
                div_f_src[j]   = div_f_reg[j-1];
            end
            trial[j] = DIVW'(div_ad_src[j]) << (NDIV - 1 - j);
            if (div_rem_src[j] >= trial[j])
            begin
                div_rem_next[j] = div_rem_src[j] - trial[j];
                div_q_next[j]   = div_q_src[j] | ((CB-1)'(1) << (NDIV - 1 - j));
            end
            else
            begin
                div_rem_next[j] = div_rem_src[j];
                div_q_next[j]   = div_q_src[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < NDIV; j++)
            begin
                div_rem_reg[j] <= div_rem_next[j];
                div_q_reg[j]   <= div_q_next[j];
                div_ad_reg[j]  <= div_ad_src[j];
                div_f_reg[j]   <= div_f_src[j];
            end
        end
    end

    // ---------------- output stage ----------------
    rth_pkg::result_t res_next;
    flags_t           f_last;
    logic [CB-2:0]    dist_val;

    assign f_last   = div_f_reg[NDIV-1];
    assign dist_val = f_last.sat ? '1 : div_q_reg[NDIV-1];

    always_comb
    begin
        res_next          = '0;
        res_next.outcome  = rth_pkg::OUT_HIT;
        priority if (f_last.par)
            res_next.outcome = rth_pkg::OUT_PARALLEL;
        else if (f_last.behind)
            res_next.outcome = rth_pkg::OUT_BEHIND;
        else if (f_last.outside)
        begin
            res_next.outcome  = rth_pkg::OUT_OUTSIDE;
            res_next.distance = dist_val;
        end
        else
        begin
            res_next.hit      = 1'b1;
            res_next.distance = dist_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

endmodule
`default_nettype wire

// ===== tb/rth_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rth_checker
// Watches the triangle, result and register ports of the hit test block,
// predicts each result with exact wide integer arithmetic and compares it
// field by field with what comes out, in order.
// ============================================================================
module rth_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  rth_pkg::triangle_t                  in_data,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  rth_pkg::result_t                    out_data,
    input  logic                                cfg_write,
    input  logic [rth_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [rth_pkg::COORD_BITS-1:0]      cfg_data,
    output int                                  fails,
    output int                                  pending,
    output int                                  outcome_seen [4]
);

    localparam int CBW  = rth_pkg::COORD_BITS;
    localparam int FRAC = rth_pkg::FRAC_BITS_DEFAULT;
    localparam logic [CBW-2:0] MAX_DIST = '1;

    typedef logic signed [383:0] wide_t;

    logic signed [CBW-1:0] ray_org [3];
    logic signed [CBW-1:0] ray_dir [3];
    logic [CBW-2:0]        eps;
    rth_pkg::result_t      expected_results [$];

    function automatic wide_t cross_dot(wide_t nx, wide_t ny, wide_t nz,
                                        wide_t ex, wide_t ey, wide_t ez,
                                        wide_t ux, wide_t uy, wide_t uz);
        return nx * (ey * uz - ez * uy) + ny * (ez * ux - ex * uz)
             + nz * (ex * uy - ey * ux);
    endfunction

    function automatic rth_pkg::result_t predict_hit(rth_pkg::triangle_t tri_in);
        wide_t   ax, ay, az, bx, by, bz, cx, cy, cz;
        wide_t   ox, oy, oz, dx, dy, dz;
        wide_t   e0x, e0y, e0z, e2x, e2y, e2z, nx, ny, nz;
        wide_t   den, num, lim, an, ad, quo, wx, wy, wz, s;
        wide_t   ex [3], ey [3], ez [3], ux [3], uy [3], uz [3];
        rth_pkg::result_t r;
        ax = tri_in.a_x; ay = tri_in.a_y; az = tri_in.a_z;
        bx = tri_in.b_x; by = tri_in.b_y; bz = tri_in.b_z;
        cx = tri_in.c_x; cy = tri_in.c_y; cz = tri_in.c_z;
        ox = ray_org[0]; oy = ray_org[1]; oz = ray_org[2];
        dx = ray_dir[0]; dy = ray_dir[1]; dz = ray_dir[2];
        e0x = bx - ax; e0y = by - ay; e0z = bz - az;
        e2x = cx - ax; e2y = cy - ay; e2z = cz - az;
        nx = e0y * e2z - e0z * e2y;
        ny = e0z * e2x - e0x * e2z;
        nz = e0x * e2y - e0y * e2x;
        den = nx * dx + ny * dy + nz * dz;
        num = nx * (ax - ox) + ny * (ay - oy) + nz * (az - oz);
        lim = {353'b0, eps};
        lim = lim <<< (2 * FRAC);
        r.hit = 1'b0;
        r.distance = '0;
        ad = (den < 0) ? -den : den;
        if (den == 0 || ad < lim)
        begin
            r.outcome = rth_pkg::OUT_PARALLEL;
            return r;
        end
        if (num != 0 && ((num < 0) != (den < 0)))
        begin
            r.outcome = rth_pkg::OUT_BEHIND;
            return r;
        end
        an = (num < 0) ? -num : num;
        quo = (an <<< FRAC) / ad;
        r.distance = (quo > wide_t'(MAX_DIST)) ? MAX_DIST : quo[CBW-2:0];
        // den * (P - a), kept exact
        wx = den * (ox - ax) + num * dx;
        wy = den * (oy - ay) + num * dy;
        wz = den * (oz - az) + num * dz;
        ex[0] = e0x;     ey[0] = e0y;     ez[0] = e0z;
        ux[0] = wx;      uy[0] = wy;      uz[0] = wz;
        ex[1] = cx - bx; ey[1] = cy - by; ez[1] = cz - bz;
        ux[1] = wx - den * e0x; uy[1] = wy - den * e0y; uz[1] = wz - den * e0z;
        ex[2] = ax - cx; ey[2] = ay - cy; ez[2] = az - cz;
        ux[2] = wx - den * e2x; uy[2] = wy - den * e2y; uz[2] = wz - den * e2z;
        for (int k = 0; k < 3; k++)
        begin
            s = cross_dot(nx, ny, nz, ex[k], ey[k], ez[k], ux[k], uy[k], uz[k]);
            if (s != 0 && ((s < 0) != (den < 0)))
            begin
                r.outcome = rth_pkg::OUT_OUTSIDE;
                return r;
            end
        end
        r.hit = 1'b1;
        r.outcome = rth_pkg::OUT_HIT;
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        rth_pkg::result_t want;
        if (!rst_n)
        begin
            ray_org[0] <= '0;
            ray_org[1] <= '0;
            ray_org[2] <= '0;
            ray_dir[0] <= '0;
            ray_dir[1] <= '0;
            ray_dir[2] <= 32'sd65536;
            eps        <= 31'd1;
            fails      <= 0;
            for (int i = 0; i < 4; i++)
                outcome_seen[i] <= 0;
            expected_results.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(predict_hit(in_data));
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    if (fails < 10)
                        $display("ERROR: result with nothing expected: %p", out_data);
                    fails <= fails + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    outcome_seen[out_data.outcome] <= outcome_seen[out_data.outcome] + 1;
                    if (out_data.hit !== want.hit || out_data.distance !== want.distance
                        || out_data.outcome !== want.outcome)
                    begin
                        if (fails < 10)
                            $display({"ERROR: mismatch exp hit=%0d dist=%0d outcome=%s,",
                                      " got hit=%0d dist=%0d outcome=%s"},
                                     want.hit, want.distance, want.outcome.name(),
                                     out_data.hit, out_data.distance,
                                     out_data.outcome.name());
                        fails <= fails + 1;
                    end
                end
            end
            if (cfg_write)
            begin
                case (rth_pkg::cfg_reg_t'(cfg_index))
                    rth_pkg::CFG_ORIGIN_X: ray_org[0] <= cfg_data;
                    rth_pkg::CFG_ORIGIN_Y: ray_org[1] <= cfg_data;
                    rth_pkg::CFG_ORIGIN_Z: ray_org[2] <= cfg_data;
                    rth_pkg::CFG_DIR_X:    ray_dir[0] <= cfg_data;
                    rth_pkg::CFG_DIR_Y:    ray_dir[1] <= cfg_data;
                    rth_pkg::CFG_DIR_Z:    ray_dir[2] <= cfg_data;
                    rth_pkg::CFG_EPSILON:  eps <= cfg_data[CBW-2:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Drives triangle streams against a series of ray settings, with random
// idling on both sides, a long output hold-off and a full drain; the
// checker beside the block predicts and compares every result.
// ============================================================================
module tb;

    localparam int   F       = 65536;
    localparam int   LATENCY = 44;
    localparam int   IDXB    = rth_pkg::CFG_INDEX_BITS;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    rth_pkg::triangle_t                  in_data = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    rth_pkg::result_t                    out_data;
    logic                                cfg_write = 1'b0;
    logic [IDXB-1:0]                     cfg_index = '0;
    logic [rth_pkg::COORD_BITS-1:0]      cfg_data = '0;

    int fails;
    int pending;
    int outcome_seen [4];
    int triangles_sent = 0;
    int hold_cycles = 0;
    bit quiet_tx = 1'b0;
    bit quiet_rx = 1'b0;
    logic signed [31:0] cur_org [3];
    logic signed [31:0] cur_dir [3];

    always #5 clk = ~clk;

    ray_triangle_hit_test u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rth_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fails        (fails),
        .pending      (pending),
        .outcome_seen (outcome_seen)
    );

    // result side: long hold-off on request, otherwise random stall bursts
    initial
    begin
        int burst_left;
        burst_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else if (burst_left > 0)
            begin
                out_stall <= 1'b1;
                burst_left--;
            end
            else if (!quiet_rx && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                burst_left = $urandom_range(0, 9);
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    task automatic send_triangle(input rth_pkg::triangle_t tri_item);
        bit taken;
        if (!quiet_tx && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= tri_item;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
        triangles_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // writes the whole ray setup, block idle
    task automatic set_ray(input logic signed [31:0] ox, oy, oz, dx, dy, dz,
                           input logic [30:0] eps);
        logic [31:0] vals [7];
        vals = '{ox, oy, oz, dx, dy, dz, {1'b0, eps}};
        cur_org = '{ox, oy, oz};
        cur_dir = '{dx, dy, dz};
        for (int i = 0; i < 7; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= IDXB'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic rth_pkg::triangle_t make_tri(input logic signed [31:0] v [9]);
        return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
    endfunction

    // mostly triangles placed around a point on the ray line, some noise
    function automatic rth_pkg::triangle_t random_tri(input int reach);
        logic signed [31:0] v [9];
        logic signed [31:0] cen [3];
        int sel, s, r;
        sel = $urandom_range(0, 99);
        if (sel < 15)
        begin
            foreach (v[i]) v[i] = $urandom;
        end
        else if (sel < 22)
        begin
            foreach (v[i]) v[i] = ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
        end
        else
        begin
            s = $urandom_range(0, reach) - reach / 8;
            r = 1 << $urandom_range(2, 22);
            for (int k = 0; k < 3; k++)
                cen[k] = cur_org[k] + cur_dir[k] * s;
            foreach (v[i])
                v[i] = cen[i % 3] + $signed($urandom_range(0, 2 * r)) - r;
            if (sel < 28)
            begin
                // collinear or repeated vertex
                for (int k = 0; k < 3; k++)
                    v[6 + k] = (sel < 25) ? v[k] : 2 * v[3 + k] - v[k];
            end
        end
        return make_tri(v);
    endfunction

    task automatic random_burst(input int count, input int reach);
        for (int i = 0; i < count; i++)
            send_triangle(random_tri(reach));
    endtask

    initial
    begin
        rth_pkg::triangle_t base;
        cur_org = '{0, 0, 0};
        cur_dir = '{0, 0, F};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // directed cases with the reset ray: +z from the origin, threshold 1
        base = make_tri('{-F, -F, F, F, -F, F, 0, F, F});
        send_triangle(base);                                         // hit
        send_triangle(make_tri('{-F, -F, F, 0, F, F, F, -F, F}));    // hit, other winding
        send_triangle(make_tri('{-F, -F, -F, F, -F, -F, 0, F, -F})); // behind
        send_triangle(make_tri('{9*F, -F, F, 11*F, -F, F, 10*F, F, F})); // outside
        send_triangle(make_tri('{0, 0, 0, 0, F, 0, 0, 0, F}));       // parallel
        send_triangle(make_tri('{F, F, F, F, F, F, F, F, F}));       // degenerate
        send_triangle(make_tri('{0, 0, F, F, 0, F, 0, F, F}));       // on a vertex
        send_triangle(make_tri('{-F, 0, F, F, 0, F, 0, F, F}));      // on an edge
        send_triangle(make_tri('{-F, -F, 0, F, -F, 0, 0, F, 0}));    // t == 0
        send_triangle(make_tri('{-1, -1, 32'sh7fffffff, 1, -1, 32'sh7fffffff,
                                 0, 1, 32'sh7fffffff}));             // far, tiny
        send_triangle('1);
        send_triangle('0);
        send_triangle({9{32'h7fffffff}});
        send_triangle({9{32'h80000000}});
        send_triangle(make_tri('{32'sh80000000, 32'sh80000000, F,
                                 32'sh7fffffff, 32'sh80000000, F,
                                 0, 32'sh7fffffff, F}));             // huge hit
        send_triangle(make_tri('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                                 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                                 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000}));
        random_burst(150, 40);
        drain();

        // tilted ray, zero threshold; long hold-off on results first
        set_ray(3*F, -2*F, -5*F, F/2, -F/4, F, 31'd0);
        quiet_tx = 1'b1;
        hold_cycles = 300;
        random_burst(120, 40);
        quiet_tx = 1'b0;
        random_burst(100, 40);
        drain();

        // raw direction of one unit: large and saturated distances
        set_ray($urandom_range(0, 4*F) - 2*F, -7*F, 12345, 0, 0, 1, 31'd0);
        random_burst(110, 1 << 20);
        drain();
        random_burst(110, 1 << 20);
        drain();

        // extreme ray registers and the largest threshold
        set_ray(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                32'sh80000000, 32'sh7fffffff, -1, 31'h7fffffff);
        random_burst(200, 40);
        drain();

        // fully random ray
        set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                31'($urandom));
        random_burst(210, 40);
        drain();

        // diagonal ray, moderate threshold, no idling on either side
        set_ray(0, 0, 0, F, F, F, 31'd1 << 20);
        quiet_tx = 1'b1;
        quiet_rx = 1'b1;
        random_burst(240, 40);
        drain();

        $display("Sent %0d triangles over six ray settings: %0d hits, %0d parallel,",
                 triangles_sent, outcome_seen[rth_pkg::OUT_HIT],
                 outcome_seen[rth_pkg::OUT_PARALLEL]);
        $display("  %0d behind, %0d outside; %0d mismatches",
                 outcome_seen[rth_pkg::OUT_BEHIND], outcome_seen[rth_pkg::OUT_OUTSIDE],
                 fails);
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rth_pkg.sv
src/rth_mul.sv
src/ray_triangle_hit_test.sv
tb/rth_checker.sv
tb/tb.sv
